// ----- hdl/gftl_pkg.sv -----
`timescale 1ns / 1ps

package gftl_pkg;

    localparam int COORD_W = 32;
    localparam int FIELD_W = 24;
    localparam int FRAC_W  = 16;
    localparam int LOC_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int SAMPLE_W = 3 * FIELD_W;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DZ = 3'd5;

    localparam logic [COORD_W-1:0] INV_RESET = 32'h0100_0000;

    typedef struct packed {
        logic                        req_type;
        logic signed [FIELD_W-1:0]   sample_x;
        logic signed [FIELD_W-1:0]   sample_y;
        logic signed [FIELD_W-1:0]   sample_z;
        logic signed [COORD_W-1:0]   coord_x;
        logic signed [COORD_W-1:0]   coord_y;
        logic signed [COORD_W-1:0]   coord_z;
    } in_req_t;

    typedef struct packed {
        logic                        inside_res;
        logic signed [FIELD_W-1:0]   field_out_x;
        logic signed [FIELD_W-1:0]   field_out_y;
        logic signed [FIELD_W-1:0]   field_out_z;
    } res_t;

    typedef struct packed {
        logic             ok;
        logic [LOC_W-1:0] loc;
    } axis_loc_t;

endpackage

// ----- hdl/grid_field_trilinear_lookup_unit.sv -----
`timescale 1ns / 1ps
// Trilinear lookup into a 3-D vector field map held on an NX x NY x NZ grid.
// Input channel s_valid/s_ready/s_data carries requests: an append request
// stores one sample at the next grid position (x-major, z fastest), samples
// past the end of the map are dropped and give no result. A query request
// maps its point to grid coordinates through the origin and inverse spacing
// registers and returns one result on m_valid/m_ready/m_data: inside_res and
// the blended field, or zero when the point is not strictly inside.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must write
// them only while idle, as the block does not enforce this. A query result
// passes seven register stages. Throughput: one request per cycle while the
// receiver does not stall; the eight corners come from eight parity banks read together.
// Stages: input, subtract, 32x32 multiply, bank read, x/y/z blends.
// Reset clears the pipeline valids and the sample counter; map contents are
// undefined until loaded. When the receiver stalls the whole pipeline holds
// and s_ready drops.
module grid_field_trilinear_lookup_unit
    import gftl_pkg::*;
#(
    parameter int NX = 32,
    parameter int NY = 32,
    parameter int NZ = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_req_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output res_t                  m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_W-1:0]    cfg_wdata
);

    localparam int XW = $clog2(NX);
    localparam int YW = $clog2(NY);
    localparam int ZW = $clog2(NZ);

    logic signed [COORD_W-1:0] x_min_reg, y_min_reg, z_min_reg;
    logic        [COORD_W-1:0] inv_dx_reg, inv_dy_reg, inv_dz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg  <= '0;
            y_min_reg  <= '0;
            z_min_reg  <= '0;
            inv_dx_reg <= INV_RESET;
            inv_dy_reg <= INV_RESET;
            inv_dz_reg <= INV_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_X_MIN:  x_min_reg  <= cfg_wdata;
                CFG_Y_MIN:  y_min_reg  <= cfg_wdata;
                CFG_Z_MIN:  z_min_reg  <= cfg_wdata;
                CFG_INV_DX: inv_dx_reg <= cfg_wdata;
                CFG_INV_DY: inv_dy_reg <= cfg_wdata;
                CFG_INV_DZ: inv_dz_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic adv;
    logic accept;
    logic [7:1] v_reg;
    logic [7:1] v_next;

    assign adv     = !v_reg[7] || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    assign v_next = {v_reg[6:1], accept && (s_data.req_type == REQ_QUERY)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= v_next;
        end
    end

    // stage 1: query point
    logic signed [COORD_W-1:0] cx1_reg, cy1_reg, cz1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx1_reg <= s_data.coord_x;
            cy1_reg <= s_data.coord_y;
            cz1_reg <= s_data.coord_z;
        end
    end

    // stages 2-3: local coordinates
    axis_loc_t lx, ly, lz;

    gftl_axis #(.N(NX)) u_ax (
        .aclk(aclk), .en(adv), .coord(cx1_reg), .min_val(x_min_reg),
        .inv(inv_dx_reg), .res(lx)
    );
    gftl_axis #(.N(NY)) u_ay (
        .aclk(aclk), .en(adv), .coord(cy1_reg), .min_val(y_min_reg),
        .inv(inv_dy_reg), .res(ly)
    );
    gftl_axis #(.N(NZ)) u_az (
        .aclk(aclk), .en(adv), .coord(cz1_reg), .min_val(z_min_reg),
        .inv(inv_dz_reg), .res(lz)
    );

    logic [XW-1:0] cell_x;
    logic [YW-1:0] cell_y;
    logic [ZW-1:0] cell_z;

    assign cell_x = lx.loc[FRAC_W +: XW];
    assign cell_y = ly.loc[FRAC_W +: YW];
    assign cell_z = lz.loc[FRAC_W +: ZW];

    // stage 4: corner read
    logic [7:0][SAMPLE_W-1:0] corner;

    gftl_map #(.NX(NX), .NY(NY), .NZ(NZ)) u_map (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(accept && (s_data.req_type == REQ_APPEND)),
        .wr_data({s_data.sample_x, s_data.sample_y, s_data.sample_z}),
        .rd_en(adv), .cx(cell_x), .cy(cell_y), .cz(cell_z),
        .rd_data(corner)
    );

    logic              ok4_reg, ok5_reg, ok6_reg, ok7_reg;
    logic [FRAC_W-1:0] fx4_reg, fy4_reg, fz4_reg, fy5_reg, fz5_reg, fz6_reg;
    logic [2:0]        par4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ok4_reg  <= lx.ok && ly.ok && lz.ok;
            fx4_reg  <= lx.loc[FRAC_W-1:0];
            fy4_reg  <= ly.loc[FRAC_W-1:0];
            fz4_reg  <= lz.loc[FRAC_W-1:0];
            par4_reg <= {cell_x[0], cell_y[0], cell_z[0]};
            ok5_reg  <= ok4_reg;
            fy5_reg  <= fy4_reg;
            fz5_reg  <= fz4_reg;
            ok6_reg  <= ok5_reg;
            fz6_reg  <= fz5_reg;
            ok7_reg  <= ok6_reg;
        end
    end

    // stages 5-7: blend along x, y, z for each component
    logic signed [FIELD_W-1:0] fout [3];

    for (genvar c = 0; c < 3; c++) begin : g_comp
        logic signed [FIELD_W-1:0] s5 [4];
        logic signed [FIELD_W-1:0] s6 [2];

        for (genvar e = 0; e < 4; e++) begin : g_x
            logic [2:0] b0, b1;
            assign b0 = {1'b0, 2'(e)} ^ par4_reg;
            assign b1 = {1'b1, 2'(e)} ^ par4_reg;
            gftl_lerp u_l (
                .aclk(aclk), .en(adv),
                .a(corner[b0][(2-c)*FIELD_W +: FIELD_W]),
                .b(corner[b1][(2-c)*FIELD_W +: FIELD_W]),
                .w(fx4_reg), .r_reg(s5[e])
            );
        end

        for (genvar k = 0; k < 2; k++) begin : g_y
            gftl_lerp u_l (
                .aclk(aclk), .en(adv), .a(s5[k]), .b(s5[2 + k]),
                .w(fy5_reg), .r_reg(s6[k])
            );
        end

        gftl_lerp u_lz (
            .aclk(aclk), .en(adv), .a(s6[0]), .b(s6[1]),
            .w(fz6_reg), .r_reg(fout[c])
        );
    end

    assign m_valid            = v_reg[7];
    assign m_data.inside_res  = ok7_reg;
    assign m_data.field_out_x = ok7_reg ? fout[0] : '0;
    assign m_data.field_out_y = ok7_reg ? fout[1] : '0;
    assign m_data.field_out_z = ok7_reg ? fout[2] : '0;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v_reg))
        else $error("pipeline valids moved during stall");

    a_append_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.req_type == REQ_APPEND) |=> !v_reg[1])
        else $error("append request entered the query pipeline");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.inside_res |-> (m_data.field_out_x == '0)
            && (m_data.field_out_y == '0) && (m_data.field_out_z == '0))
        else $error("outside point with nonzero field");

endmodule

// ----- hdl/gftl_axis.sv -----
`timescale 1ns / 1ps

module gftl_axis
    import gftl_pkg::*;
#(
    parameter int N = 32
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] coord,
    input  logic signed [COORD_W-1:0] min_val,
    input  logic        [COORD_W-1:0] inv,
    output axis_loc_t                 res
);

    localparam logic [LOC_W-1:0] LIM = LOC_W'((N - 1) << FRAC_W);

    logic signed [COORD_W:0]     diff_reg;
    logic signed [COORD_W:0]     diff_next;
    logic                        pos_reg;
    logic [2*COORD_W-1:0]        prod_reg;
    logic [2*COORD_W-1:0]        prod_next;
    logic [LOC_W-1:0]            loc;

    assign diff_next = {coord[COORD_W-1], coord} - {min_val[COORD_W-1], min_val};
    assign prod_next = {{COORD_W{1'b0}}, diff_reg[COORD_W-1:0]} * {{COORD_W{1'b0}}, inv};

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= diff_next;
            pos_reg  <= ~diff_reg[COORD_W] && (diff_reg != '0);
            prod_reg <= prod_next;
        end
    end

    // prod < 2^48 keeps loc inside 24 bits
    assign loc     = prod_reg[24 +: LOC_W];
    assign res.loc = loc;
    assign res.ok  = pos_reg && (prod_reg[2*COORD_W-1:48] == '0)
                     && (loc != '0) && (loc < LIM);

endmodule

// ----- hdl/gftl_map.sv -----
`timescale 1ns / 1ps

module gftl_map
    import gftl_pkg::*;
#(
    parameter int NX = 32,
    parameter int NY = 32,
    parameter int NZ = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [SAMPLE_W-1:0]          wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(NX)-1:0]        cx,
    input  logic [$clog2(NY)-1:0]        cy,
    input  logic [$clog2(NZ)-1:0]        cz,
    output logic [7:0][SAMPLE_W-1:0]     rd_data
);

    localparam int XW  = $clog2(NX);
    localparam int YW  = $clog2(NY);
    localparam int ZW  = $clog2(NZ);
    localparam int HX  = (NX + 1) / 2;
    localparam int HY  = (NY + 1) / 2;
    localparam int HZ  = (NZ + 1) / 2;
    localparam int BD  = HX * HY * HZ;
    localparam int AW  = (BD > 1) ? $clog2(BD) : 1;
    localparam int MAPLEN = NX * NY * NZ;
    localparam int CW  = $clog2(MAPLEN + 1);

    logic [CW-1:0] wcnt_reg;
    logic [XW-1:0] wx_reg;
    logic [YW-1:0] wy_reg;
    logic [ZW-1:0] wz_reg;
    logic          full;
    logic          wr_go;
    logic [2:0]    wr_bank;
    logic [AW-1:0] wr_addr;

    assign full    = (wcnt_reg == CW'(MAPLEN));
    assign wr_go   = wr_en && !full;
    assign wr_bank = {wx_reg[0], wy_reg[0], wz_reg[0]};
    assign wr_addr = AW'(int'(wx_reg >> 1) * (HY * HZ) + int'(wy_reg >> 1) * HZ
                         + int'(wz_reg >> 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg <= '0;
            wx_reg   <= '0;
            wy_reg   <= '0;
            wz_reg   <= '0;
        end else if (wr_go) begin
            wcnt_reg <= wcnt_reg + 1'b1;
            if (wz_reg == ZW'(NZ - 1)) begin
                wz_reg <= '0;
                if (wy_reg == YW'(NY - 1)) begin
                    wy_reg <= '0;
                    wx_reg <= wx_reg + 1'b1;
                end else begin
                    wy_reg <= wy_reg + 1'b1;
                end
            end else begin
                wz_reg <= wz_reg + 1'b1;
            end
        end
    end

    // parity banks: corner (i,j,k) lives in bank {i[0],j[0],k[0]}
    for (genvar b = 0; b < 8; b++) begin : g_bank
        localparam logic PI = 1'((b >> 2) & 1);
        localparam logic PJ = 1'((b >> 1) & 1);
        localparam logic PK = 1'(b & 1);

        logic [SAMPLE_W-1:0] mem [BD];
        logic [XW-1:0] ci;
        logic [YW-1:0] cj;
        logic [ZW-1:0] ck;
        logic [AW-1:0] rd_addr;

        assign ci = cx + XW'(cx[0] != PI);
        assign cj = cy + YW'(cy[0] != PJ);
        assign ck = cz + ZW'(cz[0] != PK);
        assign rd_addr = AW'(int'(ci >> 1) * (HY * HZ) + int'(cj >> 1) * HZ
                             + int'(ck >> 1));

        always_ff @(posedge aclk) begin
            if (wr_go && wr_bank == 3'(b)) begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
                rd_data[b] <= mem[rd_addr];
            end
        end
    end

endmodule

// ----- hdl/gftl_lerp.sv -----
`timescale 1ns / 1ps

module gftl_lerp
    import gftl_pkg::*;
(
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [FIELD_W-1:0] a,
    input  logic signed [FIELD_W-1:0] b,
    input  logic        [FRAC_W-1:0]  w,
    output logic signed [FIELD_W-1:0] r_reg
);

    localparam int PW = FIELD_W + FRAC_W + 2;

    logic signed [FIELD_W:0]   d;
    logic signed [PW-1:0]      p;
    logic signed [PW-1:0]      sh;
    logic signed [FIELD_W-1:0] r_next;

    // a + round((b - a) * w / 2^16), same as the two-weight form
    assign d      = {b[FIELD_W-1], b} - {a[FIELD_W-1], a};
    assign p      = d * $signed({1'b0, w});
    assign sh     = (p + PW'(32768)) >>> FRAC_W;
    assign r_next = a + sh[FIELD_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
        end
    end

endmodule

// ----- bench/field_lookup_checker.sv -----
`timescale 1ns / 1ps

module field_lookup_checker
    import gftl_pkg::*;
#(
    parameter int NX = 32,
    parameter int NY = 32,
    parameter int NZ = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_req_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  res_t                  m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_W-1:0]    cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    localparam int MAP_LEN = NX * NY * NZ;

    logic signed [FIELD_W-1:0] map_x [MAP_LEN];
    logic signed [FIELD_W-1:0] map_y [MAP_LEN];
    logic signed [FIELD_W-1:0] map_z [MAP_LEN];
    int unsigned samples_loaded;
    logic signed [COORD_W-1:0] org_x, org_y, org_z;
    logic [COORD_W-1:0] step_inv_x, step_inv_y, step_inv_z;
    res_t field_q [$];

    function automatic logic grid_axis(input logic signed [COORD_W-1:0] c,
                                       input logic signed [COORD_W-1:0] mn,
                                       input logic [COORD_W-1:0] inv, input int n,
                                       output int cell_idx, output int frac);
        longint diff;
        logic [63:0] prod;
        logic [63:0] loc;
        diff = longint'(c) - longint'(mn);
        cell_idx = 0;
        frac = 0;
        if (diff <= 0 || inv == 0) return 1'b0;
        prod = 64'(diff) * {32'd0, inv};
        if (prod[63:48] != 0) return 1'b0;
        loc = prod >> 24;
        if (loc == 0 || loc >= (64'(n - 1) << 16)) return 1'b0;
        cell_idx = int'(loc >> 16);
        frac = int'(loc[15:0]);
        return 1'b1;
    endfunction

    function automatic longint mix(input longint a, input longint b, input int w);
        return (a * (65536 - w) + b * w + 32768) >>> 16;
    endfunction

    function automatic longint corner(input int comp, input int idx);
        case (comp)
            0: return longint'(map_x[idx]);
            1: return longint'(map_y[idx]);
            default: return longint'(map_z[idx]);
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] blend_comp(input int comp, input int base,
                                                      input int fx, input int fy,
                                                      input int fz);
        int sx;
        int sy;
        longint c00, c01, c10, c11, c0, c1, r;
        sx = NY * NZ;
        sy = NZ;
        c00 = mix(corner(comp, base), corner(comp, base + sx), fx);
        c01 = mix(corner(comp, base + 1), corner(comp, base + sx + 1), fx);
        c10 = mix(corner(comp, base + sy), corner(comp, base + sx + sy), fx);
        c11 = mix(corner(comp, base + sy + 1), corner(comp, base + sx + sy + 1), fx);
        c0 = mix(c00, c10, fy);
        c1 = mix(c01, c11, fy);
        r = mix(c0, c1, fz);
        return r[FIELD_W-1:0];
    endfunction

    function automatic res_t predict_field(input in_req_t r);
        res_t o;
        int cx, cy, cz, fx, fy, fz, base;
        logic ok;
        o = '0;
        ok = grid_axis(r.coord_x, org_x, step_inv_x, NX, cx, fx);
        ok = grid_axis(r.coord_y, org_y, step_inv_y, NY, cy, fy) && ok;
        ok = grid_axis(r.coord_z, org_z, step_inv_z, NZ, cz, fz) && ok;
        if (ok) begin
            base = cx * NY * NZ + cy * NZ + cz;
            o.inside_res = 1'b1;
            o.field_out_x = blend_comp(0, base, fx, fy, fz);
            o.field_out_y = blend_comp(1, base, fx, fy, fz);
            o.field_out_z = blend_comp(2, base, fx, fy, fz);
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            org_x <= '0;
            org_y <= '0;
            org_z <= '0;
            step_inv_x <= INV_RESET;
            step_inv_y <= INV_RESET;
            step_inv_z <= INV_RESET;
            samples_loaded = 0;
            field_q.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_X_MIN:  org_x <= cfg_wdata;
                    CFG_Y_MIN:  org_y <= cfg_wdata;
                    CFG_Z_MIN:  org_z <= cfg_wdata;
                    CFG_INV_DX: step_inv_x <= cfg_wdata;
                    CFG_INV_DY: step_inv_y <= cfg_wdata;
                    CFG_INV_DZ: step_inv_z <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_data.req_type == REQ_APPEND) begin
                    if (samples_loaded < MAP_LEN) begin
                        map_x[samples_loaded] = s_data.sample_x;
                        map_y[samples_loaded] = s_data.sample_y;
                        map_z[samples_loaded] = s_data.sample_z;
                        samples_loaded++;
                    end
                end else begin
                    field_q.push_back(predict_field(s_data));
                end
            end
            if (m_valid && m_ready) begin
                if (field_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", m_data);
                end else begin
                    want = field_q.pop_front();
                    if (m_data.inside_res !== want.inside_res ||
                        m_data.field_out_x !== want.field_out_x ||
                        m_data.field_out_y !== want.field_out_y ||
                        m_data.field_out_z !== want.field_out_z) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp in=%0d f=%0d,%0d,%0d got in=%0d f=%0d,%0d,%0d",
                                     want.inside_res, want.field_out_x, want.field_out_y,
                                     want.field_out_z, m_data.inside_res, m_data.field_out_x,
                                     m_data.field_out_y, m_data.field_out_z);
                    end
                end
            end
            pending = field_q.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import gftl_pkg::*;

    localparam int NX = 32;
    localparam int NY = 32;
    localparam int NZ = 32;
    localparam int MAP_LEN = NX * NY * NZ;
    localparam longint LIMIT = 2000000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_req_t s_data;
    logic m_valid;
    logic m_ready;
    res_t m_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0] cfg_wdata;
    int fail_count;
    int pending;
    longint cycles;
    logic src_burst;
    logic sink_burst;

    grid_field_trilinear_lookup_unit #(.NX(NX), .NY(NY), .NZ(NZ)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    field_lookup_checker #(.NX(NX), .NY(NY), .NZ(NZ)) u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int n;
        m_ready = 1'b0;
        sink_burst = 1'b0;
        forever begin
            if ($urandom_range(0, 40) == 0) sink_burst = ~sink_burst;
            n = sink_burst ? 0 : $urandom_range(0, 6);
            repeat (n) @(negedge aclk) m_ready <= 1'b0;
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send(input in_req_t r);
        int gap;
        if ($urandom_range(0, 50) == 0) src_burst = ~src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic append_sample(input logic [FIELD_W-1:0] vx, input logic [FIELD_W-1:0] vy,
                                 input logic [FIELD_W-1:0] vz);
        in_req_t r;
        logic [7*32-1:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = rnd[$bits(in_req_t)-1:0];
        r.req_type = REQ_APPEND;
        r.sample_x = vx;
        r.sample_y = vy;
        r.sample_z = vz;
        send(r);
    endtask

    task automatic query(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                         input logic [COORD_W-1:0] cz);
        in_req_t r;
        logic [7*32-1:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = rnd[$bits(in_req_t)-1:0];
        r.req_type = REQ_QUERY;
        r.coord_x = cx;
        r.coord_y = cy;
        r.coord_z = cz;
        send(r);
    endtask

    task automatic settle();
        @(negedge aclk) s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_grid(input logic [COORD_W-1:0] mn, input logic [COORD_W-1:0] inv);
        logic [CFG_IDX_W-1:0] idx [6];
        idx = '{CFG_X_MIN, CFG_Y_MIN, CFG_Z_MIN, CFG_INV_DX, CFG_INV_DY, CFG_INV_DZ};
        for (int i = 0; i < 6; i++) begin
            @(negedge aclk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= (i < 3) ? mn : inv;
        end
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] mn,
                                                      input logic [COORD_W-1:0] span);
        if ($urandom_range(0, 4) == 0) return $urandom;
        return mn + $urandom_range(0, span);
    endfunction

    initial begin
        logic [COORD_W-1:0] mins [7];
        logic [COORD_W-1:0] invs [7];
        logic [COORD_W-1:0] spans [7];
        logic [COORD_W-1:0] a, b, c;
        mins  = '{32'h0, 32'hFFF6_0000, 32'h0003_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h1234_0000, 32'h0};
        invs  = '{32'h0100_0000, 32'h0080_0000, 32'h0200_0000, 32'h0000_0100,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0};
        spans = '{32'h0020_0000, 32'h0040_0000, 32'h0010_0000, 32'hFFFF_FFFF,
                  32'h0000_2000, 32'h0000_2000, 32'h0020_0000};
        cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        src_burst = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // out-of-range register indexes are ignored
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= 3'd6;
        cfg_wdata <= 32'hDEAD_BEEF;
        @(negedge aclk) cfg_index <= 3'd7;
        @(negedge aclk) cfg_we <= 1'b0;

        append_sample(24'h800000, 24'h7FFFFF, 24'h000000);
        append_sample(24'h7FFFFF, 24'h800000, 24'hFFFFFF);
        for (int i = 2; i < MAP_LEN; i++)
            append_sample(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
        // map full: these are dropped
        repeat (3) append_sample(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));

        query(32'h0, 32'h0, 32'h0);
        query(32'h1, 32'h1, 32'h1);
        query(32'h0000_8000, 32'h0001_0000, 32'h0001_FFFF);
        query(32'h001E_FFFF, 32'h001E_FFFF, 32'h001E_FFFF);
        query(32'h001F_0000, 32'h0001_0000, 32'h0001_0000);
        query(32'h0001_0000, 32'hFFFF_FFFF, 32'h0001_0000);
        query(32'h7FFF_FFFF, 32'h0002_0000, 32'h0002_0000);
        query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        query(32'h0010_1234, 32'h000F_ABCD, 32'h0000_0001);
        query(32'h0000_0000, 32'h0005_0000, 32'h0005_0000);
        settle();

        for (int p = 0; p < 7; p++) begin
            set_grid(mins[p], invs[p]);
            query(mins[p], mins[p] + 1, mins[p] + 32'h0001_0000);
            for (int i = 0; i < 70; i++) begin
                a = pick_coord(mins[p], spans[p]);
                b = pick_coord(mins[p], spans[p]);
                c = pick_coord(mins[p], spans[p]);
                if ($urandom_range(0, 9) == 0)
                    append_sample(FIELD_W'($urandom), FIELD_W'($urandom),
                                  FIELD_W'($urandom));
                query(a, b, c);
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
